@@ design/npav_pkg.sv @@
// npav_pkg: shared widths, state encoding and controller/datapath bundles
// for the prime run generator; no dependencies
package npav_pkg;

	localparam int StartW = 16;
	localparam int CountW = 7;
	localparam int PrimeW = 17;
	// trial divisors never pass 363 for a 17-bit candidate
	localparam int DivW = 10;
	localparam int SqW = 2 * DivW;
	localparam int StepW = 5;
	localparam logic [StepW-1:0] DivSteps = StepW'(PrimeW);
	localparam logic [DivW-1:0] FirstDiv = DivW'(2);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_NEXT  = 6'b000010,
		ST_TEST  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic next_cand;
		logic div_start;
		logic div_step;
		logic inc_div;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic req_zero;
		logic below_two;
		logic sq_gt;
		logic div_last;
		logic rem_zero;
		logic last_one;
	} status_t;

endpackage

@@ design/npav_req_if.sv @@
// npav_req_if: request channel, start value and prime count
// depends on npav_pkg
interface npav_req_if;
	logic valid;
	logic ready;
	logic [npav_pkg::StartW-1:0] start_value;
	logic [npav_pkg::CountW-1:0] prime_count;

	modport source (output valid, output start_value, output prime_count, input ready);
	modport sink (input valid, input start_value, input prime_count, output ready);
endinterface

@@ design/npav_rsp_if.sv @@
// npav_rsp_if: result channel, one prime per transfer with a last flag
// depends on npav_pkg
interface npav_rsp_if;
	logic valid;
	logic ready;
	logic [npav_pkg::PrimeW-1:0] prime;
	logic last;

	modport source (output valid, output prime, output last, input ready);
	modport sink (input valid, input prime, input last, output ready);
endinterface

@@ design/npav_datapath.sv @@
// npav_datapath: candidate, trial divisor, bit-serial remainder unit,
// run counters and result register; depends on npav_pkg
module npav_datapath #(
	parameter int MAX_COUNT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npav_pkg::cmd_t                cmd,
	output npav_pkg::status_t             status,
	input  logic [npav_pkg::StartW-1:0]   start_value,
	input  logic [npav_pkg::CountW-1:0]   prime_count,
	output logic [npav_pkg::PrimeW-1:0]   prime,
	output logic                          last
);
	import npav_pkg::*;

	logic [PrimeW-1:0] cand_q;
	logic [DivW-1:0]   div_q;
	logic [PrimeW-1:0] shift_q;
	logic [DivW:0]     rem_q;
	logic [StepW-1:0]  step_q;
	logic [CountW-1:0] want_q;
	logic [CountW-1:0] emitted_q;
	logic [PrimeW-1:0] prime_q;
	logic              last_q;

	logic [DivW:0]     rem_sh;
	logic [DivW:0]     rem_nx;
	logic [SqW-1:0]    div_sq;
	logic [CountW-1:0] want_sat;

	always_comb begin
		rem_sh = {rem_q[DivW-1:0], shift_q[PrimeW-1]};
		if (rem_sh >= {1'b0, div_q}) begin
			rem_nx = rem_sh - {1'b0, div_q};
		end else begin
			rem_nx = rem_sh;
		end
	end

	assign div_sq = {{DivW{1'b0}}, div_q} * {{DivW{1'b0}}, div_q};
	assign want_sat = (prime_count > CountW'(MAX_COUNT)) ? CountW'(MAX_COUNT) : prime_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			want_q    <= '0;
			emitted_q <= '0;
		end else begin
			if (cmd.load) begin
				want_q    <= want_sat;
				emitted_q <= '0;
			end else if (cmd.emit) begin
				emitted_q <= emitted_q + CountW'(1);
			end
			if (cmd.div_start) begin
				step_q <= DivSteps;
			end else if (cmd.div_step) begin
				step_q <= step_q - StepW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_q <= {1'b0, start_value};
		end else if (cmd.next_cand) begin
			cand_q <= cand_q + PrimeW'(1);
		end
		if (cmd.next_cand) begin
			div_q <= FirstDiv;
		end else if (cmd.inc_div) begin
			div_q <= div_q + DivW'(1);
		end
		if (cmd.div_start) begin
			shift_q <= cand_q;
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			shift_q <= {shift_q[PrimeW-2:0], 1'b0};
			rem_q   <= rem_nx;
		end
		if (cmd.emit) begin
			prime_q <= cand_q;
			last_q  <= status.last_one;
		end
	end

	always_comb begin
		status.req_zero  = (prime_count == '0);
		status.below_two = (cand_q < PrimeW'(2));
		status.sq_gt     = (div_sq > {{(SqW-PrimeW){1'b0}}, cand_q});
		status.div_last  = (step_q == StepW'(1));
		status.rem_zero  = (rem_q == '0);
		status.last_one  = ((emitted_q + CountW'(1)) == want_q);
	end

	assign prime = prime_q;
	assign last  = last_q;

endmodule

@@ design/npav_ctrl.sv @@
// npav_ctrl: sequencer for candidate stepping, trial division and result
// hand-off; depends on npav_pkg
module npav_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  npav_pkg::status_t   status,
	output npav_pkg::cmd_t      cmd
);
	import npav_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					if (!status.req_zero) begin
						state_nx = ST_NEXT;
					end
				end
			end
			ST_NEXT: begin
				cmd.next_cand = 1'b1;
				state_nx      = ST_TEST;
			end
			ST_TEST: begin
				priority if (status.below_two) begin
					state_nx = ST_NEXT;
				end else if (status.sq_gt) begin
					state_nx = ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.rem_zero) begin
					state_nx = ST_NEXT;
				end else begin
					cmd.inc_div = 1'b1;
					state_nx    = ST_TEST;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = status.last_one ? ST_IDLE : ST_NEXT;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/next_primes_after_value.sv @@
// per trial divisor: a bound test, a 17-step remainder and a check; a composite candidate
// costs its step plus its divisors, a prime adds a final bound test and the emit, while
// 0 and 1 cost only the step and a bound test; one request at a time, and a zero count
// is accepted with the block staying idle; the bit-serial remainder unit sets the pace
// reset: arst_n clears sequencer, run counters and result valid; a request is taken at once
module next_primes_after_value #(
	parameter int MAX_COUNT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	npav_req_if.sink   req,
	npav_rsp_if.source rsp
);
	import npav_pkg::*;

	// command and status bundles between sequencer and datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: request accept, division steps, result transfer pacing
	npav_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: candidate walk, trial divisor, remainder unit and result register;
	// the result register lets the search run on while a prime waits for its transfer
	npav_datapath #(
		.MAX_COUNT (MAX_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.start_value (req.start_value),
		.prime_count (req.prime_count),
		.prime       (rsp.prime),
		.last        (rsp.last)
	);

endmodule
